// ===== hdl/g2j_pkg.sv =====
// Shared types, constants and small lookup functions for the Gregorian to
// Jalali date converter. No dependencies.
`default_nettype none

package g2j_pkg;

  // Divide-by-constant selection for the shared multiplier.
  typedef logic [2:0] div_sel_t;

  localparam div_sel_t DV_33  = 3'd0;  // 33-year cycle, 12053 days
  localparam div_sel_t DV_4   = 3'd1;  // 4-year cycle, 1461 days
  localparam div_sel_t DV_365 = 3'd2;  // common year
  localparam div_sel_t DV_31  = 3'd3;  // first six Jalali months
  localparam div_sel_t DV_30  = 3'd4;  // remaining Jalali months

  localparam int RecipShift = 20;

  localparam logic [11:0] BaseGYear  = 12'd1600;
  localparam logic [11:0] MinGYear   = 12'd1601;
  localparam logic [11:0] BaseJYear  = 12'd979;
  localparam logic [20:0] EpochShift = 21'd80;   // 79-day shift plus the day-1 offset
  localparam logic [15:0] Recip100   = 16'd5243; // 2^19 / 100, rounded up
  localparam logic [15:0] YearDays   = 16'd365;
  localparam logic [13:0] FirstHalf  = 14'd186;  // days in months 1..6
  localparam logic [13:0] LeapRem    = 14'd366;

  // Days in the Gregorian year before the first of the given month.
  function automatic logic [8:0] greg_month_offset(input logic [3:0] month);
    logic [8:0] off;
    unique case (month)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      default: off = 9'd334;
    endcase
    return off;
  endfunction

  // Divisor for each selection.
  function automatic logic [13:0] div_const(input div_sel_t sel);
    logic [13:0] d;
    unique case (sel)
      DV_33:   d = 14'd12053;
      DV_4:    d = 14'd1461;
      DV_365:  d = 14'd365;
      DV_31:   d = 14'd31;
      default: d = 14'd30;
    endcase
    return d;
  endfunction

  // floor(2^RecipShift / divisor): the estimate is exact or one low.
  function automatic logic [15:0] div_recip(input div_sel_t sel);
    logic [15:0] m;
    unique case (sel)
      DV_33:   m = 16'd86;
      DV_4:    m = 16'd717;
      DV_365:  m = 16'd2872;
      DV_31:   m = 16'd33825;
      default: m = 16'd34952;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gregorian_to_jalali_date.sv =====
// Gregorian to Jalali date converter, top level.
// Depends on g2j_pkg (types, divisor constants, month offset table).
`default_nettype none

// Usage
//   Input channel: in_valid / in_ready with greg_year, greg_month, greg_day.
//   Output channel: out_valid / out_ready with jal_year, jal_month, jal_day.
//   A transfer happens on a rising edge with valid and ready both high.
//   Each date yields exactly one result.
// Timing
//   One shared 20x16 multiplier does all the work under a small sequencer:
//   four steps build the Gregorian day count, then every divide by a
//   constant runs reciprocal multiply, back multiply, correction and
//   dispatch, with one more step to pick the month half. Three or four
//   divides run per date. A new date is taken only after the sequencer
//   has loaded the result and returned to idle, so dates do not overlap.
//   in_ready is high only while idle.
// Stalls
//   The result sits in an output register; the sequencer returns to idle and
//   takes the next date while a result still waits. If the previous result
//   is still unclaimed when the next one is done, the sequencer holds it.
// Reset
//   rst (synchronous, active high) idles the sequencer and drops out_valid.
//   Out-of-range inputs are clamped: year below 1601 to 1601, month 0 to 1,
//   months above 12 to 12. No other validity checks are made.

module gregorian_to_jalali_date
  import g2j_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] greg_year,
  input  wire logic [3:0]  greg_month,
  input  wire logic [4:0]  greg_day,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      jal_year,
  output logic [3:0]       jal_month,
  output logic [4:0]       jal_day
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_M100  = 4'd1;  // gy * 2^19/100
  localparam logic [3:0] ST_M400  = 4'd2;  // (gy/4) * 2^19/100
  localparam logic [3:0] ST_M365  = 4'd3;  // gy * 365
  localparam logic [3:0] ST_SUM   = 4'd4;  // assemble day count
  localparam logic [3:0] ST_DMUL  = 4'd5;  // num * reciprocal
  localparam logic [3:0] ST_DBACK = 4'd6;  // quotient estimate * divisor
  localparam logic [3:0] ST_DFIX  = 4'd7;  // remainder and correction
  localparam logic [3:0] ST_NEXT  = 4'd8;  // use quotient, pick next divide
  localparam logic [3:0] ST_MON   = 4'd9;  // split day-of-year into months

  logic [3:0]  st;
  div_sel_t    sel;

  // Payload registers
  logic [11:0] gy;
  logic [3:0]  gmonth;
  logic [4:0]  gday;
  logic [4:0]  q100;
  logic        z100;      // gy divisible by 100
  logic [2:0]  q400;
  logic        z400;      // gy/4 divisible by 100
  logic [35:0] prod;
  logic [19:0] num;
  logic [6:0]  qe;
  logic [6:0]  q;
  logic [13:0] r;
  logic [11:0] jy;

  // Shared multiplier operands
  logic [19:0] mul_a;
  logic [15:0] mul_b;

  always_comb begin
    unique case (st)
      ST_M100: begin
        mul_a = {8'd0, gy};
        mul_b = Recip100;
      end
      ST_M400: begin
        mul_a = {10'd0, gy[11:2]};
        mul_b = Recip100;
      end
      ST_M365: begin
        mul_a = {8'd0, gy};
        mul_b = YearDays;
      end
      ST_DBACK: begin
        mul_a = {13'd0, prod[26:20]};
        mul_b = {2'd0, div_const(sel)};
      end
      default: begin
        mul_a = num;
        mul_b = div_recip(sel);
      end
    endcase
  end

  // Input clamping
  logic [11:0] year_c;
  logic [3:0]  month_c;

  always_comb begin
    year_c = (greg_year < MinGYear) ? MinGYear : greg_year;
    priority if (greg_month == 4'd0) begin
      month_c = 4'd1;
    end else if (greg_month > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = greg_month;
    end
  end

  // Day count from 1600-01-01, shifted to the Jalali epoch
  logic        mult4;
  logic        leap;
  logic [20:0] count_sum;

  always_comb begin
    mult4 = (gy[1:0] == 2'd0);
    leap  = (mult4 && !z100) || (mult4 && z400);
    count_sum = {1'b0, prod[19:0]}
              + {11'd0, gy[11:2]} + {20'd0, !mult4}
              - {16'd0, q100} - {20'd0, !z100}
              + {18'd0, q400} + {20'd0, !(mult4 && z400)}
              + {12'd0, greg_month_offset(gmonth)}
              + {20'd0, (gmonth > 4'd2) && leap}
              + {16'd0, gday}
              - EpochShift;
  end

  // Remainder correction: the estimate is exact or one low
  logic [19:0] r_raw;
  logic        r_over;
  logic [19:0] dv;

  always_comb begin
    dv     = {6'd0, div_const(sel)};
    r_raw  = num - prod[19:0];
    r_over = (r_raw >= dv);
  end

  logic out_free;
  logic emit;      // last divide done and the output register can take it
  assign out_free = !out_valid || out_ready;
  assign in_ready = (st == ST_IDLE);
  assign emit     = (st == ST_NEXT) && out_free && (sel != DV_33)
                    && (sel != DV_4) && (sel != DV_365);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            st <= ST_M100;
          end
        end
        ST_M100:  st <= ST_M400;
        ST_M400:  st <= ST_M365;
        ST_M365:  st <= ST_SUM;
        ST_SUM:   st <= ST_DMUL;
        ST_DMUL:  st <= ST_DBACK;
        ST_DBACK: st <= ST_DFIX;
        ST_DFIX:  st <= ST_NEXT;
        ST_NEXT: begin
          unique case (sel)
            DV_33:  st <= ST_DMUL;
            DV_4:   st <= (r >= LeapRem) ? ST_DMUL : ST_MON;
            DV_365: st <= ST_MON;
            default: begin
              if (out_free) begin
                st <= ST_IDLE;
              end
            end
          endcase
        end
        ST_MON:   st <= ST_DMUL;
        default:  st <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (st)
      ST_IDLE: begin
        if (in_valid) begin
          gy     <= year_c - BaseGYear;
          gmonth <= month_c;
          gday   <= greg_day;
        end
      end
      ST_M400: begin
        q100 <= prod[23:19];
        z100 <= (prod[18:0] < Recip100[13:0]);
      end
      ST_M365: begin
        q400 <= prod[21:19];
        z400 <= (prod[18:0] < Recip100[13:0]);
      end
      ST_SUM: begin
        num <= count_sum[19:0];
        sel <= DV_33;
      end
      ST_DBACK: begin
        qe <= prod[26:20];
      end
      ST_DFIX: begin
        // correct the quotient and keep the remainder
        if (r_over) begin
          q <= qe + 7'd1;
          r <= 14'(r_raw - dv);
        end else begin
          q <= qe;
          r <= r_raw[13:0];
        end
      end
      ST_NEXT: begin
        unique case (sel)
          DV_33: begin
            jy  <= BaseJYear + {q, 5'd0} + {5'd0, q};
            num <= {6'd0, r};
            sel <= DV_4;
          end
          DV_4: begin
            jy <= jy + {3'd0, q, 2'd0};
            // past the leading leap year: count common years from day one
            if (r >= LeapRem) begin
              num <= {6'd0, r} - 20'd1;
              sel <= DV_365;
            end
          end
          DV_365: begin
            jy <= jy + {5'd0, q};
          end
          DV_31: begin
            if (out_free) begin
              jal_year  <= jy;
              jal_month <= q[3:0] + 4'd1;
              jal_day   <= r[4:0] + 5'd1;
            end
          end
          default: begin
            if (out_free) begin
              jal_year  <= jy;
              jal_month <= q[3:0] + 4'd7;
              jal_day   <= r[4:0] + 5'd1;
            end
          end
        endcase
      end
      ST_MON: begin
        if (r < FirstHalf) begin
          num <= {6'd0, r};
          sel <= DV_31;
        end else begin
          num <= {6'd0, r - FirstHalf};
          sel <= DV_30;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
